/* sv/twoid_pkg.sv */
// Package for the two-wire optical ID slave.
// Holds the link codes, line levels, status words and the shared types.
// No dependencies.
package twoid_pkg;

  // Widths of the items and the state.
  localparam int WORD_BITS  = 23;
  localparam int CMD_BITS   = 8;
  localparam int COUNT_W    = 5;

  // Byte that resets the link.
  localparam logic [7:0] LINK_RESET_BYTE = 8'h42;

  // Read-back levels of the data line.
  localparam logic [7:0] LINE_HIGH = 8'hFF;
  localparam logic [7:0] LINE_LOW  = 8'hFB;

  // Status words.
  localparam logic [WORD_BITS-1:0] STATUS_POWER_ON = 23'h60FFF8;
  localparam logic [WORD_BITS-1:0] STATUS_CMD_SCAN = 23'h53FFFB;
  localparam logic [WORD_BITS-1:0] STATUS_CMD_STOP = 23'h60FFF7;

  // Command codes.
  localparam logic [CMD_BITS-1:0] CMD_SCAN  = 8'h24;
  localparam logic [CMD_BITS-1:0] CMD_HIGH  = 8'hA3;
  localparam logic [CMD_BITS-1:0] CMD_LOW   = 8'h30;
  localparam logic [CMD_BITS-1:0] CMD_STOP  = 8'h56;

  // Link phases. Codes above the last member are never entered.
  typedef enum logic [2:0] {
    PH_WAIT_EDGE = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_RW_BIT    = 3'd2,
    PH_RX_CMD    = 3'd3,
    PH_TX_WORD   = 3'd4
  } phase_t;

  // One written word as it travels from the input register to the core.
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       tag_present;
  } item_t;

endpackage

/* sv/twoid_in_reg.sv */
// Input register of the two-wire optical ID slave.
// Takes one word per cycle from the input channel while the core takes its words, and hands it to the core.
// Depends on twoid_pkg.
module twoid_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         wire_byte,
  input  logic               tag_present,
  output logic               item_valid,
  input  logic               item_ready,
  output twoid_pkg::item_t   item
);

  // The register frees itself whenever the core takes its word.
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.wire_byte   <= wire_byte;
      item.tag_present <= tag_present;
    end
  end

endmodule

/* sv/twoid_core.sv */
// Link state machine and result register of the two-wire optical ID slave.
// One registered word is processed per cycle while out_ready holds;
// the line level goes to read_byte. Depends on twoid_pkg.
module twoid_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [twoid_pkg::WORD_BITS-1:0]     reader_index,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  twoid_pkg::item_t                    item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          read_byte
);

  twoid_pkg::phase_t                        phase, phase_next;
  logic                                     last_clock;
  logic [twoid_pkg::COUNT_W-1:0]            bit_count, bit_count_next;
  logic [twoid_pkg::CMD_BITS-1:0]           command_shift, command_shift_next;
  logic [twoid_pkg::WORD_BITS-1:0]          status_word, status_word_next;
  logic [twoid_pkg::WORD_BITS-1:0]          reply_word, reply_word_next;
  logic                                     power_on_pending, power_on_pending_next;
  logic [7:0]                               line_byte, line_byte_next;

  logic                                     link_reset;
  logic                                     wire_clk, wire_data, rise, low_hold;
  twoid_pkg::phase_t                        phase_cur;
  logic [twoid_pkg::COUNT_W-1:0]            tx_index;
  logic [2:0]                               rx_index;
  logic                                     advance;

  // The core takes a word whenever the result register is free or drains.
  assign item_ready = !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  assign link_reset = (item.wire_byte == twoid_pkg::LINK_RESET_BYTE);
  assign wire_clk   = item.wire_byte[0];
  assign wire_data  = item.wire_byte[1];
  assign rise       = !last_clock && wire_clk;
  assign low_hold   = !last_clock && !wire_clk;
  assign phase_cur  = link_reset ? twoid_pkg::PH_WAIT_EDGE : phase;

  // Bit positions, MSB first.
  assign tx_index = twoid_pkg::COUNT_W'(twoid_pkg::WORD_BITS - 1) - bit_count;
  assign rx_index = 3'(twoid_pkg::CMD_BITS - 1) - bit_count[2:0];

  // Next state and line level for the word in the input register.
  always_comb begin
    phase_next            = phase_cur;
    bit_count_next        = bit_count;
    command_shift_next    = command_shift;
    status_word_next      = status_word;
    reply_word_next       = reply_word;
    power_on_pending_next = link_reset ? 1'b1 : power_on_pending;
    line_byte_next        = link_reset ? twoid_pkg::LINE_HIGH : line_byte;

    case (phase_cur)
      twoid_pkg::PH_WAIT_EDGE: begin
        if (rise) begin
          phase_next = twoid_pkg::PH_WAIT_LOW;
        end
        line_byte_next = twoid_pkg::LINE_LOW;
      end
      twoid_pkg::PH_WAIT_LOW: begin
        if (item.tag_present) begin
          line_byte_next = twoid_pkg::LINE_LOW;
        end
        if (!wire_data) begin
          phase_next = twoid_pkg::PH_RW_BIT;
        end
      end
      twoid_pkg::PH_RW_BIT: begin
        if (rise) begin
          bit_count_next = '0;
          if (wire_data) begin
            phase_next         = twoid_pkg::PH_RX_CMD;
            command_shift_next = '0;
          end else begin
            phase_next = twoid_pkg::PH_TX_WORD;
            if (power_on_pending_next) begin
              status_word_next      = twoid_pkg::STATUS_POWER_ON;
              power_on_pending_next = 1'b0;
            end
            reply_word_next = item.tag_present ? reader_index : status_word_next;
          end
        end
      end
      twoid_pkg::PH_RX_CMD: begin
        if (rise && (bit_count < twoid_pkg::COUNT_W'(twoid_pkg::CMD_BITS))) begin
          if (wire_data) begin
            command_shift_next[rx_index] = 1'b1;
          end
          bit_count_next = bit_count + 1'b1;
        end else if (low_hold &&
                     (bit_count == twoid_pkg::COUNT_W'(twoid_pkg::CMD_BITS))) begin
          phase_next = twoid_pkg::PH_WAIT_LOW;
          case (command_shift)
            twoid_pkg::CMD_SCAN: begin
              line_byte_next   = twoid_pkg::LINE_HIGH;
              status_word_next = twoid_pkg::STATUS_CMD_SCAN;
            end
            twoid_pkg::CMD_HIGH: line_byte_next = twoid_pkg::LINE_HIGH;
            twoid_pkg::CMD_LOW:  line_byte_next = twoid_pkg::LINE_LOW;
            twoid_pkg::CMD_STOP: begin
              line_byte_next   = twoid_pkg::LINE_LOW;
              status_word_next = twoid_pkg::STATUS_CMD_STOP;
            end
            default: line_byte_next = twoid_pkg::LINE_HIGH;
          endcase
        end
      end
      twoid_pkg::PH_TX_WORD: begin
        if (rise && (bit_count < twoid_pkg::COUNT_W'(twoid_pkg::WORD_BITS))) begin
          line_byte_next = reply_word[tx_index] ? twoid_pkg::LINE_HIGH
                                                : twoid_pkg::LINE_LOW;
          bit_count_next = bit_count + 1'b1;
        end else if (low_hold &&
                     (bit_count == twoid_pkg::COUNT_W'(twoid_pkg::WORD_BITS))) begin
          line_byte_next = twoid_pkg::LINE_HIGH;
          phase_next     = twoid_pkg::PH_WAIT_LOW;
        end
      end
      default: begin
        // Unreachable phase codes hold everything but the clock history.
      end
    endcase
  end

  // Link state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= twoid_pkg::PH_WAIT_EDGE;
      last_clock       <= 1'b0;
      bit_count        <= '0;
      command_shift    <= '0;
      status_word      <= '0;
      reply_word       <= '0;
      power_on_pending <= 1'b1;
      line_byte        <= twoid_pkg::LINE_HIGH;
    end else if (advance) begin
      phase            <= phase_next;
      last_clock       <= wire_clk;
      bit_count        <= bit_count_next;
      command_shift    <= command_shift_next;
      status_word      <= status_word_next;
      reply_word       <= reply_word_next;
      power_on_pending <= power_on_pending_next;
      line_byte        <= line_byte_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_byte <= line_byte_next;
    end
  end

endmodule

/* sv/two_wire_optical_id_slave_top.sv */
// A word accepted into the input register is processed by the core, and its line level
// is registered in the result register as the read_byte word.
// Throughput: one word per cycle while out_ready holds; the two registers sit in series.
// The configuration write takes effect at the edge it is presented.
// Reset (rst, synchronous) empties both registers, clears the link to the
// wait-for-edge phase with a power-on report pending, line high, index zero.
module two_wire_optical_id_slave_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [twoid_pkg::WORD_BITS-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          wire_byte,
  input  logic                                tag_present,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          read_byte
);

  logic [twoid_pkg::WORD_BITS-1:0] reader_index;
  logic                            item_valid;
  logic                            item_ready;
  twoid_pkg::item_t                item;

  // Reader index register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reader_index <= '0;
    end else if (cfg_wr_en) begin
      reader_index <= cfg_wr_data;
    end
  end

  twoid_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .wire_byte   (wire_byte),
    .tag_present (tag_present),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  twoid_core u_core (
    .clk          (clk),
    .rst          (rst),
    .reader_index (reader_index),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte)
  );

endmodule

/* sv/twoid_checker.sv */
// Port-level checks for the two-wire optical ID slave, and the bind that
// attaches them to two_wire_optical_id_slave_top. Depends on twoid_pkg.
module twoid_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte))
    else $error("result word changed while stalled");

  // The line only ever reads back high or low.
  a_line_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_byte == twoid_pkg::LINE_HIGH) ||
                  (read_byte == twoid_pkg::LINE_LOW))
    else $error("read_byte is not a line level");

  // After reset both registers are empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("registers not empty after reset");

endmodule

bind two_wire_optical_id_slave_top twoid_checker u_twoid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_byte (read_byte)
);

/* dv/two_wire_optical_id_slave_top_tb.sv */
// Self-checking testbench for the two-wire optical ID slave top level.
// Depends on twoid_pkg and two_wire_optical_id_slave_top; predicts every read-back
// word in step with the input words and checks the results in order.
`timescale 1ns / 1ps

module two_wire_optical_id_slave_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 20;

  typedef logic [twoid_pkg::WORD_BITS-1:0] word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  word_t                cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           wire_byte;
  logic                 tag_present;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           read_byte;

  // Copy of the link state, advanced once per accepted input word.
  twoid_pkg::phase_t                  lk_phase;
  logic                               lk_last_clk;
  logic [twoid_pkg::COUNT_W-1:0]      lk_count;
  logic [twoid_pkg::CMD_BITS-1:0]     lk_cmd;
  word_t                              lk_status;
  word_t                              lk_reply;
  word_t                              lk_index;
  logic                               lk_power_on;
  logic [7:0]                         lk_line;

  logic [7:0] line_levels_due[$];

  int  send_gap_pct;
  int  recv_stall_pct;
  int  error_count;
  int  words_sent;
  int  words_checked;
  int  frames_sent;
  int  index_writes;
  int  idle_cycles;
  bit  need_resync;

  two_wire_optical_id_slave_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .wire_byte  (wire_byte),
    .tag_present(tag_present),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_byte  (read_byte)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Link state after reset, with the tag index cleared.
  function automatic void reset_link_state();
    lk_phase    = twoid_pkg::PH_WAIT_EDGE;
    lk_last_clk = 1'b0;
    lk_count    = '0;
    lk_cmd      = '0;
    lk_status   = '0;
    lk_reply    = '0;
    lk_index    = '0;
    lk_power_on = 1'b1;
    lk_line     = twoid_pkg::LINE_HIGH;
  endfunction

  // Advances the link by one sampled word and returns the line level it leaves.
  function automatic logic [7:0] next_line_level(input logic [7:0] wb, input logic tag);
    logic c;
    logic d;
    logic rise;
    logic low_hold;
    if (wb == twoid_pkg::LINK_RESET_BYTE) begin
      lk_phase    = twoid_pkg::PH_WAIT_EDGE;
      lk_power_on = 1'b1;
      lk_line     = twoid_pkg::LINE_HIGH;
    end
    c        = wb[0];
    d        = wb[1];
    rise     = !lk_last_clk && c;
    low_hold = !lk_last_clk && !c;
    case (lk_phase)
      twoid_pkg::PH_WAIT_EDGE: begin
        if (rise) lk_phase = twoid_pkg::PH_WAIT_LOW;
        lk_line = twoid_pkg::LINE_LOW;
      end
      twoid_pkg::PH_WAIT_LOW: begin
        if (tag) lk_line = twoid_pkg::LINE_LOW;
        if (!d) lk_phase = twoid_pkg::PH_RW_BIT;
      end
      twoid_pkg::PH_RW_BIT: begin
        if (rise) begin
          lk_count = '0;
          if (d) begin
            lk_phase = twoid_pkg::PH_RX_CMD;
            lk_cmd   = '0;
          end else begin
            lk_phase = twoid_pkg::PH_TX_WORD;
            if (lk_power_on) begin
              lk_status   = twoid_pkg::STATUS_POWER_ON;
              lk_power_on = 1'b0;
            end
            lk_reply = tag ? lk_index : lk_status;
          end
        end
      end
      twoid_pkg::PH_RX_CMD: begin
        if (rise && lk_count < twoid_pkg::CMD_BITS) begin
          lk_cmd[twoid_pkg::CMD_BITS-1-lk_count] = d;
          lk_count++;
        end else if (low_hold && lk_count == twoid_pkg::CMD_BITS) begin
          lk_phase = twoid_pkg::PH_WAIT_LOW;
          case (lk_cmd)
            twoid_pkg::CMD_SCAN: begin
              lk_line   = twoid_pkg::LINE_HIGH;
              lk_status = twoid_pkg::STATUS_CMD_SCAN;
            end
            twoid_pkg::CMD_HIGH: lk_line = twoid_pkg::LINE_HIGH;
            twoid_pkg::CMD_LOW:  lk_line = twoid_pkg::LINE_LOW;
            twoid_pkg::CMD_STOP: begin
              lk_line   = twoid_pkg::LINE_LOW;
              lk_status = twoid_pkg::STATUS_CMD_STOP;
            end
            default:  lk_line = twoid_pkg::LINE_HIGH;
          endcase
        end
      end
      twoid_pkg::PH_TX_WORD: begin
        if (rise && lk_count < twoid_pkg::WORD_BITS) begin
          lk_line = lk_reply[twoid_pkg::WORD_BITS-1-lk_count] ? twoid_pkg::LINE_HIGH
                                                             : twoid_pkg::LINE_LOW;
          lk_count++;
        end else if (low_hold && lk_count == twoid_pkg::WORD_BITS) begin
          lk_line  = twoid_pkg::LINE_HIGH;
          lk_phase = twoid_pkg::PH_WAIT_LOW;
        end
      end
      default: ;
    endcase
    lk_last_clk = c;
    return lk_line;
  endfunction

  // A wire sample with the given clock and data, random upper bits, never the reset code.
  function automatic logic [7:0] wire_sample(input logic c, input logic d);
    logic [7:0] b;
    b      = 8'($urandom);
    b[1:0] = {d, c};
    if (b == twoid_pkg::LINK_RESET_BYTE) b[7] = 1'b1;
    return b;
  endfunction

  // Sends one input word, possibly after idle cycles, and records its expected line level.
  task automatic send_wire_word(input logic [7:0] wb, input logic tag);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    wire_byte   <= wb;
    tag_present <= tag;
    do @(posedge clk); while (!in_ready);
    line_levels_due.insert(line_levels_due.size(), next_line_level(wb, tag));
    words_sent++;
  endtask

  // Holds the input low until every expected result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (line_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the tag index while the block is idle.
  task automatic write_reader_index(input word_t value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= word_t'($urandom);
    lk_index = value;
    index_writes++;
  endtask

  // One transfer on the link: an optional resync, the read/write bit, the command or
  // the word clocked through, and two low samples to close. A broken one stops early.
  task automatic send_frame(input bit broken);
    logic [7:0]    seq[$];
    logic          is_read;
    logic          tag;
    logic          d;
    logic [7:0]    cmd;
    int            nbits;
    int            cut;
    is_read = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       cmd = twoid_pkg::CMD_SCAN;
      1:       cmd = twoid_pkg::CMD_HIGH;
      2:       cmd = twoid_pkg::CMD_LOW;
      3:       cmd = twoid_pkg::CMD_STOP;
      default: cmd = 8'($urandom);
    endcase
    if (need_resync || $urandom_range(0, 4) == 0) begin
      seq.insert(seq.size(), twoid_pkg::LINK_RESET_BYTE);
      seq.insert(seq.size(), wire_sample(1'b1, 1'($urandom)));
    end
    repeat ($urandom_range(0, 2)) seq.insert(seq.size(), wire_sample(1'($urandom), 1'b1));
    seq.insert(seq.size(), wire_sample(1'b0, 1'b0));
    seq.insert(seq.size(), wire_sample(1'b1, !is_read));
    nbits = is_read ? twoid_pkg::WORD_BITS : twoid_pkg::CMD_BITS;
    for (int i = 0; i < nbits; i++) begin
      d = is_read ? 1'($urandom) : cmd[twoid_pkg::CMD_BITS-1-i];
      seq.insert(seq.size(), wire_sample(1'b0, d));
      seq.insert(seq.size(), wire_sample(1'b1, d));
    end
    seq.insert(seq.size(), wire_sample(1'b0, 1'($urandom)));
    seq.insert(seq.size(), wire_sample(1'b0, 1'($urandom)));
    cut = broken ? int'($urandom_range(1, seq.size() - 1)) : seq.size();
    tag = 1'($urandom_range(0, 1));
    for (int i = 0; i < cut; i++) begin
      send_wire_word(seq[i], ($urandom_range(0, 9) == 0) ? !tag : tag);
    end
    need_resync = broken;
    frames_sent++;
  endtask

  // A short burst of unrelated samples, now and then the reset code among them.
  task automatic send_noise_burst();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      b = ($urandom_range(0, 7) == 0) ? twoid_pkg::LINK_RESET_BYTE : 8'($urandom);
      send_wire_word(b, 1'($urandom));
    end
    need_resync = 1'b1;
  endtask

  // Mostly well-formed transfers, some cut short, some noise; the tag index is
  // rewritten between transfers every so often, the extremes among the values.
  task automatic run_traffic(input int n_words);
    int stop_at;
    int next_write;
    int pick;
    int sel;
    stop_at    = words_sent + n_words;
    next_write = words_sent + 150;
    sel        = 0;
    while (words_sent < stop_at) begin
      if (words_sent >= next_write) begin
        case (sel % 5)
          0:       write_reader_index('0);
          1:       write_reader_index('1);
          2:       write_reader_index(23'h555555);
          3:       write_reader_index(23'h2AAAAA);
          default: write_reader_index(word_t'($urandom));
        endcase
        sel++;
        next_write = words_sent + 150;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) send_frame(1'b0);
      else if (pick < 85) send_frame(1'b1);
      else send_noise_burst();
    end
  endtask

  // Bring-up by hand: the reset code, wire extremes, a present tag while waiting
  // for data low, and a write carrying the stop command.
  task automatic test_link_bring_up();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_reader_index('1);
    send_wire_word(twoid_pkg::LINK_RESET_BYTE, 1'b0);
    send_wire_word(8'h00, 1'b0);
    send_wire_word(8'hFF, 1'b1);
    send_wire_word(8'hFF, 1'b1);
    send_wire_word(8'h00, 1'b0);
    send_wire_word(wire_sample(1'b1, 1'b1), 1'b1);
    for (int i = twoid_pkg::CMD_BITS - 1; i >= 0; i--) begin
      send_wire_word(wire_sample(1'b0, twoid_pkg::CMD_STOP[i]), 1'b0);
      send_wire_word(wire_sample(1'b1, twoid_pkg::CMD_STOP[i]), 1'b1);
    end
    send_wire_word(8'hFC, 1'b0);
    send_wire_word(8'h00, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_sender_gaps();
    send_gap_pct   = 16;
    recv_stall_pct = 48;
    need_resync    = 1'b1;
    run_traffic(580);
    write_reader_index(word_t'($urandom));
  endtask

  task automatic test_receiver_stalls();
    send_gap_pct   = 48;
    recv_stall_pct = 16;
    run_traffic(580);
    write_reader_index('0);
  endtask

  task automatic test_back_to_back();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_traffic(580);
  endtask

  // Receiver side: ready drops at random according to the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Each accepted result word is compared with the oldest expected line level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (line_levels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected read_byte word %02h", read_byte));
      end else begin
        if (read_byte !== line_levels_due[0]) begin
          report_mismatch($sformatf("read_byte %02h, expected %02h (result %0d)",
                                    read_byte, line_levels_due[0], words_checked));
        end
        void'(line_levels_due.pop_front());
        words_checked++;
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    wire_byte      <= '0;
    tag_present    <= 1'b0;
    out_ready      <= 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    words_sent     = 0;
    words_checked  = 0;
    frames_sent    = 0;
    index_writes   = 0;
    idle_cycles    = 0;
    need_resync    = 1'b0;
    reset_link_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_link_bring_up();
    test_sender_gaps();
    test_receiver_stalls();
    test_back_to_back();

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (line_levels_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived",
                                line_levels_due.size()));
    end
    $display("Sent %0d wire words in %0d transfers, checked %0d read-back words.",
             words_sent, frames_sent, words_checked);
    $display("Tag index rewritten %0d times; %0d mismatches.", index_writes, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
